FILE: hw/rtl/udiv_pkg.sv
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared constants and command/status types for the unsigned divider.
// ----------------------------------------------------------------------------
package udiv_pkg;

  // Width of every numeric field on the stream ports.
  localparam int unsigned FIELD_W = 64;

  // Default operand width actually used by the divider.
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;  // capture operands, clear partial remainder
    logic step;  // one restoring shift-and-subtract iteration
    logic emit;  // copy result into the output register
  } udiv_cmd_t;

endpackage

FILE: hw/rtl/udiv_dpath.sv
// ----------------------------------------------------------------------------
// udiv_dpath
// Operand, partial remainder and quotient registers with one restoring
// subtract stage, plus the output word register.
// ----------------------------------------------------------------------------
module udiv_dpath
  import udiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  udiv_cmd_t          cmd_i,
  input  logic [FIELD_W-1:0] dividend_i,
  input  logic [FIELD_W-1:0] divisor_i,
  output logic [FIELD_W-1:0] quotient_o,
  output logic [FIELD_W-1:0] remainder_o,
  output logic               div_by_zero_o
);

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;  // holds dividend bits, quotient shifts in
  logic [W-1:0] den_q, den_d;
  logic         dz_q, dz_d;
  logic [W:0]   shifted;
  logic [W:0]   diff;

  logic [FIELD_W-1:0] q_out_q, q_out_d;
  logic [FIELD_W-1:0] r_out_q, r_out_d;
  logic               dz_out_q, dz_out_d;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    rem_d    = rem_q;
    quo_d    = quo_q;
    den_d    = den_q;
    dz_d     = dz_q;
    q_out_d  = q_out_q;
    r_out_d  = r_out_q;
    dz_out_d = dz_out_q;
    if (cmd_i.load) begin
      rem_d = '0;
      quo_d = dividend_i[W-1:0];
      den_d = divisor_i[W-1:0];
      dz_d  = (divisor_i[W-1:0] == '0);
    end else if (cmd_i.step) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      // zero divisor reports zero quotient and remainder
      q_out_d  = dz_q ? '0 : FIELD_W'(quo_q);
      r_out_d  = dz_q ? '0 : FIELD_W'(rem_q);
      dz_out_d = dz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      quo_q    <= '0;
      den_q    <= '0;
      dz_q     <= 1'b0;
      q_out_q  <= '0;
      r_out_q  <= '0;
      dz_out_q <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      quo_q    <= quo_d;
      den_q    <= den_d;
      dz_q     <= dz_d;
      q_out_q  <= q_out_d;
      r_out_q  <= r_out_d;
      dz_out_q <= dz_out_d;
    end
  end

  assign quotient_o    = q_out_q;
  assign remainder_o   = r_out_q;
  assign div_by_zero_o = dz_out_q;

endmodule

FILE: hw/rtl/udiv_ctrl.sv
// ----------------------------------------------------------------------------
// udiv_ctrl
// Sequencer: accepts a word, runs DATA_WIDTH iterations, hands the result
// to the output register once it is free.
// ----------------------------------------------------------------------------
module udiv_ctrl
  import udiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output udiv_cmd_t cmd_o
);

  localparam int unsigned CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  logic             out_free;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_vld_d  = out_vld_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(DATA_WIDTH - 1);
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // never overwrite a result word that is still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_vld_q || out_ready_i))
    else $error("udiv_ctrl: emit over pending result");

  // a new result only appears right after the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN))
    else $error("udiv_ctrl: result valid without finish");

  // iteration count runs out exactly when leaving the run state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && state_d == ST_FIN) |-> (cnt_q == '0))
    else $error("udiv_ctrl: run ended early");

endmodule

FILE: hw/rtl/unsigned_divider_64_core.sv
// ----------------------------------------------------------------------------
// unsigned_divider_64_core
// Unsigned restoring divider: quotient, remainder and divide-by-zero flag.
// ----------------------------------------------------------------------------
// One input word carries dividend and divisor; one output word returns the
// quotient, the remainder and a divide-by-zero flag. Only the low DATA_WIDTH
// bits of each operand are used, and results are zero-extended to 64 bits.
// A zero divisor returns quotient 0, remainder 0 and the flag set. Each word
// passes through a load step, one shift-and-subtract iteration per quotient
// bit through a single subtractor, and a step that moves the result into the
// output register. The output register is separate from the working
// registers, so the next word is accepted while a finished result still
// waits on m_axis_tready_i; the block only stalls in its finish state if
// that result is still not taken. Nothing is kept between words.
// ----------------------------------------------------------------------------
module unsigned_divider_64_core
  import udiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF  // 8 .. 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input word
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [2*FIELD_W-1:0] s_axis_tdata_i,   // [63:0] dividend, [127:64] divisor
  // result word
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [2*FIELD_W-1:0] m_axis_tdata_o,   // [63:0] quotient, [127:64] remainder
  output logic                 m_axis_tuser_o    // [0] div_by_zero
);

  udiv_cmd_t          cmd;
  logic [FIELD_W-1:0] quotient;
  logic [FIELD_W-1:0] remainder;

  udiv_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  udiv_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .dividend_i    (s_axis_tdata_i[FIELD_W-1:0]),
    .divisor_i     (s_axis_tdata_i[2*FIELD_W-1:FIELD_W]),
    .quotient_o    (quotient),
    .remainder_o   (remainder),
    .div_by_zero_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {remainder, quotient};

endmodule

FILE: bench/udiv_result_checker.sv
// ----------------------------------------------------------------------------
// udiv_result_checker
// Watches both stream ports of the divider and checks every result word.
// ----------------------------------------------------------------------------
// Each accepted input word is turned into an expected quotient, remainder and
// divide-by-zero flag and queued. Each accepted result word is compared field
// by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module udiv_result_checker
  import udiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [2*FIELD_W-1:0] s_axis_tdata_i,   // [63:0] dividend, [127:64] divisor
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [2*FIELD_W-1:0] m_axis_tdata_i,   // [63:0] quotient, [127:64] remainder
  input  logic                 m_axis_tuser_i,   // [0] div_by_zero
  output int unsigned          errors_o,
  output int unsigned          outstanding_o
);

  localparam logic [FIELD_W-1:0] OPERAND_MASK = {FIELD_W{1'b1}} >> (FIELD_W - DATA_WIDTH);

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic               div_by_zero;
  } quot_rem_t;

  quot_rem_t quot_rem_q[$];

  // Bits above DATA_WIDTH are dropped; a zero divisor gives zeros and the flag.
  function automatic quot_rem_t divide_operands(logic [FIELD_W-1:0] dividend,
                                                logic [FIELD_W-1:0] divisor);
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    quot_rem_t          res;
    num = dividend & OPERAND_MASK;
    den = divisor & OPERAND_MASK;
    res = '0;
    if (den == '0) begin
      res.div_by_zero = 1'b1;
    end else begin
      res.quotient  = num / den;
      res.remainder = num % den;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    quot_rem_t want;
    if (!rst_ni) begin
      quot_rem_q.delete();
      errors_o = 0;
      outstanding_o <= 0;
    end else begin
      // results first, so a word never matches an input taken at the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (quot_rem_q.size() == 0) begin
          errors_o = errors_o + 1;
          $display("%0t: unexpected result word, got quotient %h remainder %h flag %b",
                   $time, m_axis_tdata_i[FIELD_W-1:0], m_axis_tdata_i[2*FIELD_W-1:FIELD_W],
                   m_axis_tuser_i);
        end else begin
          want = quot_rem_q.pop_front();
          if (m_axis_tdata_i[FIELD_W-1:0] !== want.quotient) begin
            errors_o = errors_o + 1;
            $display("%0t: quotient mismatch, expected %h, got %h",
                     $time, want.quotient, m_axis_tdata_i[FIELD_W-1:0]);
          end
          if (m_axis_tdata_i[2*FIELD_W-1:FIELD_W] !== want.remainder) begin
            errors_o = errors_o + 1;
            $display("%0t: remainder mismatch, expected %h, got %h",
                     $time, want.remainder, m_axis_tdata_i[2*FIELD_W-1:FIELD_W]);
          end
          if (m_axis_tuser_i !== want.div_by_zero) begin
            errors_o = errors_o + 1;
            $display("%0t: div_by_zero mismatch, expected %b, got %b",
                     $time, want.div_by_zero, m_axis_tuser_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        quot_rem_q.push_back(divide_operands(s_axis_tdata_i[FIELD_W-1:0],
                                             s_axis_tdata_i[2*FIELD_W-1:FIELD_W]));
      end
      outstanding_o <= quot_rem_q.size();
    end
  end

endmodule

FILE: bench/tb_unsigned_divider_64_core.sv
// ----------------------------------------------------------------------------
// tb_unsigned_divider_64_core
// Stream-level test of the 64-bit unsigned restoring divider.
// ----------------------------------------------------------------------------
// A directed set of corner operands is followed by random operand pairs
// mixing random alignment shifts, zero divisors, small and power-of-two
// divisors, exact multiples and dividends below the divisor. Both ports
// idle at random except for one quiet stretch. The checker instance owns
// prediction and comparison; this module drives words and gives the verdict.
// ----------------------------------------------------------------------------
module tb_unsigned_divider_64_core;
  import udiv_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1500;
  localparam int unsigned QUIET_FIRST  = 600;   // no idling on either port
  localparam int unsigned QUIET_LAST   = 900;   //   for words in this range
  localparam int unsigned IDLE_PCT     = 8;
  localparam int unsigned DRAIN_CYCLES = 80;    // a bit over one division
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no word moving
  localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] TOP_BIT  = {1'b1, {(FIELD_W-1){1'b0}}};

  logic                 clk  = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [2*FIELD_W-1:0] s_tdata = '0;   // [63:0] dividend, [127:64] divisor
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [2*FIELD_W-1:0] m_tdata;        // [63:0] quotient, [127:64] remainder
  logic                 m_tuser;        // [0] div_by_zero
  logic                 quiet = 1'b0;   // suppresses random idling on both ports

  int unsigned errors;
  int unsigned outstanding;
  int unsigned idle_cycles = 0;
  int unsigned words_sent  = 0;
  int unsigned zero_divs   = 0;
  int unsigned below_divs  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  unsigned_divider_64_core #(
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  udiv_result_checker #(
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .errors_o        (errors),
    .outstanding_o   (outstanding)
  );

  // Result side: drop tready about 8% of cycles unless in the quiet stretch.
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: a correct block keeps words moving, so a long silence means it hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [FIELD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one dividend/divisor word and returns at the edge that takes it.
  // tready is looked at on the falling edge, clear of the rising-edge updates.
  task automatic send_word(input logic [FIELD_W-1:0] dividend,
                           input logic [FIELD_W-1:0] divisor);
    logic taken;
    while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {rand_word(), rand_word()};  // junk while not valid
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {divisor, dividend};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    words_sent++;
    if (divisor == '0) begin
      zero_divs++;
    end else if (dividend < divisor) begin
      below_divs++;
    end
  endtask

  initial begin
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    int unsigned        pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: zero divisor, dividend below divisor, equal operands,
    // full-width operands and operands around the 32-bit boundary.
    send_word('0, '0);
    send_word(ALL_ONES, '0);
    send_word(64'h1, '0);
    send_word('0, 64'h1);
    send_word('0, ALL_ONES);
    send_word(ALL_ONES, 64'h1);
    send_word(ALL_ONES, ALL_ONES);
    send_word(ALL_ONES, ALL_ONES - 1);
    send_word(ALL_ONES - 1, ALL_ONES);
    send_word(64'h1, 64'h1);
    send_word(TOP_BIT, 64'h1);
    send_word(TOP_BIT, TOP_BIT);
    send_word(ALL_ONES, TOP_BIT);
    send_word(TOP_BIT - 1, TOP_BIT);
    send_word(64'hFFFF_FFFF, 64'h1);
    send_word(64'h1_0000_0000, 64'h3);
    send_word(64'hFFFF_FFFF, 64'h1_0000_0000);
    send_word(64'h1_0000_0000, 64'hFFFF_FFFF);
    send_word(64'h8000_0000, 64'h8000_0000);
    send_word(64'd12345, 64'd7);
    send_word(64'd100, 64'd10);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      quiet <= (k >= QUIET_FIRST) && (k < QUIET_LAST);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        a = rand_word() >> $urandom_range(0, 63);
        b = '0;
      end else if (pick < 20) begin
        a = rand_word();
        b = rand_word();
      end else if (pick < 50) begin
        // random shifts spread both operand magnitudes over their whole range
        a = rand_word() >> $urandom_range(0, 63);
        b = rand_word() >> $urandom_range(0, 63);
      end else if (pick < 60) begin
        a = rand_word();
        b = FIELD_W'($urandom_range(1, 255));
      end else if (pick < 70) begin
        // dividend strictly below divisor
        a = rand_word() >> $urandom_range(0, 63);
        b = rand_word() >> $urandom_range(0, 63);
        if (a > b) begin
          {a, b} = {b, a};
        end
        if (a == b) begin
          b = a + 1;
          if (b == '0) begin
            a = ALL_ONES - 1;
            b = ALL_ONES;
          end
        end
      end else if (pick < 78) begin
        // exact multiple: remainder should come back zero
        b = (rand_word() >> $urandom_range(32, 63)) | 64'h1;
        a = b * (rand_word() >> $urandom_range(32, 63));
      end else if (pick < 86) begin
        a = rand_word();
        b = 64'h1 << $urandom_range(0, 63);
      end else if (pick < 92) begin
        a = rand_word() >> $urandom_range(0, 63);
        b = a;
      end else begin
        a = rand_word();
        b = ALL_ONES >> $urandom_range(0, 63);
      end
      send_word(a, b);
    end

    s_tvalid <= 1'b0;
    quiet    <= 1'b0;

    // Drain: the watchdog covers a result that never comes.
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Divided %0d operand pairs: %0d by zero, %0d with dividend below divisor.",
             words_sent, zero_divs, below_divs);
    $display("Both ports idled at random apart from words %0d to %0d.",
             QUIET_FIRST, QUIET_LAST - 1);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
